/* hdl/ffea_pkg.sv */
// ----------------------------------------------------------------------------
// ffea_pkg
// Shared types and constants of the first-fit extent allocator.
// ----------------------------------------------------------------------------
package ffea_pkg;

  localparam int TABLE_ENTRIES_DEF = 64;

  localparam logic [15:0] AREA_FIRST_RST = 16'd299;
  localparam logic [15:0] AREA_END_RST   = 16'd2880;

  // Command codes carried on the input tuser.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_ALLOC = 1'b1;

  // Configuration register indexes.
  localparam logic REG_AREA_FIRST = 1'b0;
  localparam logic REG_AREA_END   = 1'b1;

  // Result status codes.
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_NO_ROOM = 1'b1;

  typedef struct packed {
    logic        used;
    logic [15:0] start;
    logic [15:0] length;
  } extent_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic clr_write;
    logic wr_read;
    logic wr_commit;
    logic scan_first;
    logic scan_next;
    logic cand_move;
    logic load_result;
    logic no_room;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic index_ok;
    logic fits;
    logic clash;
    logic scan_last;
  } dpath_stat_t;

endpackage

/* hdl/ffea_ctrl.sv */
// ----------------------------------------------------------------------------
// ffea_ctrl
// Sequencer of the allocator: clearing pass, entry writes, first-fit scan
// passes and the output handshake.
// ----------------------------------------------------------------------------
module ffea_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic                   in_command,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output ffea_pkg::ctrl_cmd_t    cmd,
  input  ffea_pkg::dpath_stat_t  stat
);
  import ffea_pkg::*;

  typedef enum logic [6:0] {
    ST_CLEAR     = 7'b0000001,
    ST_IDLE      = 7'b0000010,
    ST_WR_READ   = 7'b0000100,
    ST_WR_COMMIT = 7'b0001000,
    ST_CHECK     = 7'b0010000,
    ST_SCAN      = 7'b0100000,
    ST_DONE      = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   no_room, no_room_next;
  logic   out_valid;
  logic   out_free;

  assign out_free = !out_valid || m_tready;
  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;

  always_comb begin
    state_next   = state;
    no_room_next = no_room;
    cmd          = '0;
    cmd.no_room  = no_room;
    case (state)
      ST_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (stat.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.accept   = 1'b1;
          no_room_next = 1'b0;
          state_next   = (in_command == CMD_ALLOC) ? ST_CHECK : ST_WR_READ;
        end
      end
      ST_WR_READ: begin
        cmd.wr_read = 1'b1;
        state_next  = stat.index_ok ? ST_WR_COMMIT : ST_DONE;
      end
      ST_WR_COMMIT: begin
        cmd.wr_commit = 1'b1;
        state_next    = ST_DONE;
      end
      ST_CHECK: begin
        if (stat.fits) begin
          cmd.scan_first = 1'b1;
          state_next     = ST_SCAN;
        end else begin
          no_room_next = 1'b1;
          state_next   = ST_DONE;
        end
      end
      ST_SCAN: begin
        // A clash moves the window; if it still fits, a fresh pass over the table starts.
        if (stat.clash) begin
          cmd.cand_move = 1'b1;
          state_next    = ST_CHECK;
        end else if (stat.scan_last) begin
          state_next = ST_DONE;
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.load_result = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      no_room   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      no_room <= no_room_next;
      if (cmd.load_result) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* hdl/ffea_dpath.sv */
// ----------------------------------------------------------------------------
// ffea_dpath
// Extent memory, configuration registers, used-sector total, candidate
// window arithmetic and the result register.
// ----------------------------------------------------------------------------
module ffea_dpath #(
  parameter int TABLE_ENTRIES = ffea_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic                   cfg_index,
  input  logic [15:0]            cfg_wdata,
  input  logic                   in_command,
  input  logic [5:0]             in_entry_index,
  input  logic                   in_entry_used,
  input  logic [15:0]            in_entry_start,
  input  logic [15:0]            in_entry_length,
  input  logic [15:0]            in_request_length,
  input  ffea_pkg::ctrl_cmd_t    cmd,
  output ffea_pkg::dpath_stat_t  stat,
  output logic                   out_status,
  output logic [15:0]            out_found_start,
  output logic [14:0]            out_free_kilobytes
);
  import ffea_pkg::*;

  localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int TOTAL_W = 16 + $clog2(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  extent_t mem [TABLE_ENTRIES];
  extent_t rdata;

  logic [15:0]        area_first;
  logic [15:0]        area_end;
  logic [TOTAL_W-1:0] total;
  logic [IDX_W-1:0]   clr_idx;
  logic [IDX_W-1:0]   scan_idx;
  logic [16:0]        cand;

  logic        item_cmd;
  logic [5:0]  item_idx;
  logic        item_used;
  logic [15:0] item_start;
  logic [15:0] item_len;
  logic [15:0] item_req;

  logic [IDX_W-1:0]   rd_addr;
  logic [IDX_W-1:0]   wr_addr;
  logic [IDX_W-1:0]   item_addr;
  logic               mem_we;
  extent_t            wdata;
  logic [17:0]        win_end;
  logic [16:0]        ent_end;
  logic [TOTAL_W-1:0] old_part;
  logic [TOTAL_W-1:0] new_part;
  logic [15:0]        area_size;
  logic [TOTAL_W-1:0] free_diff;
  logic [14:0]        free_kb;

  assign item_addr = IDX_W'(item_idx);

  // Window and entry bounds.
  assign win_end = 18'(cand) + 18'(item_req);
  assign ent_end = 17'(rdata.start) + 17'(rdata.length);

  assign stat.clr_last  = (clr_idx == LAST_IDX);
  assign stat.index_ok  = (32'(item_idx) < 32'(TABLE_ENTRIES));
  assign stat.fits      = (win_end <= 18'(area_end));
  assign stat.clash     = rdata.used && (cand < ent_end) && (18'(rdata.start) < win_end);
  assign stat.scan_last = (scan_idx == LAST_IDX);

  always_comb begin
    case (1'b1)
      cmd.wr_read:    rd_addr = item_addr;
      cmd.scan_first: rd_addr = '0;
      cmd.scan_next:  rd_addr = stat.scan_last ? '0 : scan_idx + 1'b1;
      default:        rd_addr = scan_idx;
    endcase
  end

  always_comb begin
    mem_we  = cmd.clr_write || cmd.wr_commit;
    wr_addr = cmd.clr_write ? clr_idx : item_addr;
    if (cmd.clr_write) begin
      wdata = '0;
    end else begin
      wdata.used   = item_used;
      wdata.start  = item_start;
      wdata.length = item_len;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wdata;
    end
    rdata <= mem[rd_addr];
  end

  assign old_part = rdata.used ? TOTAL_W'(rdata.length) : '0;
  assign new_part = item_used ? TOTAL_W'(item_len) : '0;

  // Free space: area size less used sectors, halved, zero when not positive.
  always_comb begin
    area_size = area_end - area_first;
    free_diff = TOTAL_W'(area_size) - total;
    if (area_end <= area_first || total >= TOTAL_W'(area_size)) begin
      free_kb = '0;
    end else begin
      free_kb = free_diff[15:1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      area_first <= AREA_FIRST_RST;
      area_end   <= AREA_END_RST;
      total      <= '0;
      clr_idx    <= '0;
      scan_idx   <= '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_AREA_FIRST: area_first <= cfg_wdata;
          REG_AREA_END:   area_end   <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.clr_write) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (cmd.wr_commit) begin
        total <= total - old_part + new_part;
      end
      if (cmd.scan_first) begin
        scan_idx <= '0;
      end else if (cmd.scan_next) begin
        scan_idx <= scan_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_cmd   <= in_command;
      item_idx   <= in_entry_index;
      item_used  <= in_entry_used;
      item_start <= in_entry_start;
      item_len   <= in_entry_length;
      item_req   <= in_request_length;
      cand       <= {1'b0, area_first};
    end else if (cmd.cand_move) begin
      cand <= ent_end;
    end
    if (cmd.load_result) begin
      out_status         <= cmd.no_room ? STATUS_NO_ROOM : STATUS_OK;
      out_found_start    <= (item_cmd == CMD_ALLOC && !cmd.no_room) ? cand[15:0] : '0;
      out_free_kilobytes <= free_kb;
    end
  end

endmodule

/* hdl/first_fit_extent_allocator.sv */
// ----------------------------------------------------------------------------
// first_fit_extent_allocator
// Extent table with entry writes and first-fit allocation of sector runs.
// ----------------------------------------------------------------------------
// Input words arrive on s_tvalid/s_tready; tuser carries the command (write
// one table entry or allocate a run). Every word yields one result word on
// m_tvalid/m_tready with a status, the found start sector and the free space.
// The data area is set through cfg_wr_en/cfg_index/cfg_wdata; the user must
// write it only while idle, which the block does not enforce. A write reads
// its entry in ST_WR_READ, writes it in ST_WR_COMMIT if the index is valid
// and loads the result in ST_DONE. An allocation runs passes over the table,
// one entry per cycle from the single memory read port, and every clash with
// a used extent starts another pass. One word is worked on at a time; the
// next is taken as soon as the result sits in the output register. After
// reset the block clears the table, one entry per cycle, and holds s_tready
// low until the table is cleared. When the receiver stalls, the result is
// held and a following result waits until the output register is free.
// ----------------------------------------------------------------------------
module first_fit_extent_allocator #(
  parameter int TABLE_ENTRIES = ffea_pkg::TABLE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // entry_index[5:0], entry_used[6], entry_start[22:7], entry_length[38:23],
  // request_length[54:39], zero pad[55]
  input  logic [55:0] s_tdata,
  // command[0]
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // status[0], found_start[16:1], free_kilobytes[31:17]
  output logic [31:0] m_tdata,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);
  import ffea_pkg::*;

  ctrl_cmd_t   cmd;
  dpath_stat_t stat;
  logic        out_status;
  logic [15:0] out_found_start;
  logic [14:0] out_free_kilobytes;

  ffea_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .in_command (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .cmd        (cmd),
    .stat       (stat)
  );

  ffea_dpath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dpath (
    .clk                (clk),
    .rst                (rst),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_command         (s_tuser),
    .in_entry_index     (s_tdata[5:0]),
    .in_entry_used      (s_tdata[6]),
    .in_entry_start     (s_tdata[22:7]),
    .in_entry_length    (s_tdata[38:23]),
    .in_request_length  (s_tdata[54:39]),
    .cmd                (cmd),
    .stat               (stat),
    .out_status         (out_status),
    .out_found_start    (out_found_start),
    .out_free_kilobytes (out_free_kilobytes)
  );

  assign m_tdata = {out_free_kilobytes, out_found_start, out_status};

  // One word in flight: an accepted word closes the input until it is done.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while a word is still being worked on");

  // A no-room result never reports a start sector.
  a_no_room_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[0] == STATUS_NO_ROOM) |-> (m_tdata[16:1] == 16'd0))
    else $error("no-room result carries a start sector");

  // The table clearing pass follows reset, so input stays closed.
  a_clear_after_reset: assert property (@(posedge clk)
    ($past(rst) && !rst) |-> !s_tready)
    else $error("input opened before the table was cleared");

endmodule

/* tb/tb_extent_pkg.sv */
// ----------------------------------------------------------------------------
// tb_extent_pkg
// Word types and the result tracker for the first-fit extent allocator bench.
// ----------------------------------------------------------------------------
// The tracker keeps its own copy of the extent table, the used-sector total
// and the data area bounds. It turns every accepted command word into the
// result word that the block must return, and checks returned words in order.
// ----------------------------------------------------------------------------
package tb_extent_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  import ffea_pkg::*;

  typedef struct {
    logic        cmd;
    logic [5:0]  slot;
    logic        used;
    logic [15:0] start;
    logic [15:0] length;
    logic [15:0] req;
  } alloc_cmd_t;

  // Same bit layout as the result tdata, status in bit 0.
  typedef struct packed {
    logic [14:0] free_kb;
    logic [15:0] start;
    logic        status;
  } alloc_reply_t;

  class extent_tracker;
    extent_t      slots [TABLE_ENTRIES_DEF];
    int unsigned  used_total;
    int unsigned  area_first;
    int unsigned  area_end;
    alloc_reply_t replies_due [$];
    int           failures;

    function new();
      foreach (slots[i]) slots[i] = '0;
      used_total = 0;
      area_first = 32'(AREA_FIRST_RST);
      area_end   = 32'(AREA_END_RST);
      failures   = 0;
    endfunction

    function void set_area(logic [15:0] first, logic [15:0] last);
      area_first = 32'(first);
      area_end   = 32'(last);
    endfunction

    function logic [14:0] free_kb();
      int unsigned size;
      int unsigned kb;
      if (area_end <= area_first) return '0;
      size = area_end - area_first;
      if (used_total >= size) return '0;
      kb = (size - used_total) / 2;
      return kb[14:0];
    endfunction

    // First-fit search. Every clash moves the candidate past the clashing
    // extent and restarts the scan at entry zero, so a used zero-length entry
    // strictly inside the window pulls the candidate up to its start.
    function bit first_fit(int unsigned len, output int unsigned at);
      int unsigned cand;
      int unsigned stop;
      bit          clash;
      cand = area_first;
      at   = 0;
      while (cand + len <= area_end) begin
        clash = 1'b0;
        foreach (slots[i]) begin
          if (!clash && slots[i].used) begin
            stop = 32'(slots[i].start) + 32'(slots[i].length);
            if (cand < stop && 32'(slots[i].start) < cand + len) begin
              cand  = stop;
              clash = 1'b1;
            end
          end
        end
        if (!clash) begin
          at = cand;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void take_command(alloc_cmd_t c);
      alloc_reply_t r;
      int unsigned  at;
      r = '0;
      if (c.cmd == CMD_WRITE) begin
        if (slots[c.slot].used) used_total -= 32'(slots[c.slot].length);
        slots[c.slot].used   = c.used;
        slots[c.slot].start  = c.start;
        slots[c.slot].length = c.length;
        if (c.used) used_total += 32'(c.length);
      end else if (first_fit(32'(c.req), at)) begin
        r.start = at[15:0];
      end else begin
        r.status = STATUS_NO_ROOM;
      end
      // Free space is taken after a write of the same word has landed.
      r.free_kb = free_kb();
      replies_due.push_back(r);
    endfunction

    function void mismatch(string field, logic [15:0] want, logic [15:0] got);
      failures++;
      if (failures <= 10) $display("ERROR: %s expected %0d, got %0d", field, want, got);
    endfunction

    function void check_reply(alloc_reply_t got);
      alloc_reply_t want;
      if (replies_due.size() == 0) begin
        failures++;
        if (failures <= 10) $display("ERROR: result word %h with nothing outstanding", got);
        return;
      end
      want = replies_due.pop_front();
      if (got.status !== want.status) begin
        mismatch("status", 16'(want.status), 16'(got.status));
      end
      if (got.start !== want.start) mismatch("found_start", want.start, got.start);
      if (got.free_kb !== want.free_kb) begin
        mismatch("free_kilobytes", 16'(want.free_kb), 16'(got.free_kb));
      end
    endfunction
  endclass

endpackage

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Stream-level bench for the first-fit extent allocator.
// ----------------------------------------------------------------------------
// A directed opener hits the field extremes, zero-length extents, zero and
// oversized requests and a whole-area cover. Random table writes and
// allocations follow over several data area settings, the reversed and empty
// areas among them. Both stream sides idle at random, the result side holds
// off long enough to back the block up, and every result word is checked
// against the tracker in order.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ffea_pkg::*;
  import tb_extent_pkg::*;

  logic        clk;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata   = '0;
  logic        s_tuser   = CMD_WRITE;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [31:0] m_tdata;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_index = REG_AREA_FIRST;
  logic [15:0] cfg_wdata = '0;

  logic [15:0] phase_first [7] = '{16'd0, 16'd1000, 16'd65535, 16'd0, 16'd65535,
                                   16'd299, 16'd40000};
  logic [15:0] phase_last  [7] = '{16'd65535, 16'd1400, 16'd0, 16'd0, 16'd65535,
                                   16'd2880, 16'd65535};

  extent_tracker sb;
  bit            send_calm = 1'b0;

  first_fit_extent_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // An allocation can restart its scan once per extent, so this timeout
  // leaves plenty of room.
  initial begin
    #300_000_000;
    $display("FAILURE");
    $finish;
  end

  // Idle lengths come in stretches: now and then a side switches to a calm
  // spell with no gaps at all.
  function automatic int pick_gap(inout bit calm);
    if ($urandom_range(0, 39) == 0) calm = !calm;
    return calm ? 0 : int'($urandom_range(0, 11));
  endfunction

  function automatic alloc_cmd_t write_cmd(logic [5:0] slot, logic used,
                                           logic [15:0] start, logic [15:0] length);
    alloc_cmd_t c;
    c = '{cmd: CMD_WRITE, slot: slot, used: used, start: start, length: length,
          req: 16'd0};
    return c;
  endfunction

  function automatic alloc_cmd_t alloc_cmd(logic [15:0] req);
    alloc_cmd_t c;
    c = '{cmd: CMD_ALLOC, slot: 6'd0, used: 1'b0, start: 16'd0, length: 16'd0,
          req: req};
    return c;
  endfunction

  task automatic send_word(alloc_cmd_t c);
    int gap;
    gap = pick_gap(send_calm);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= c.cmd;
    s_tdata  <= {1'b0, c.req, c.length, c.start, c.used, c.slot};
    do @(posedge clk); while (!s_tready);
    sb.take_command(c);
  endtask

  task automatic wait_all_replies();
    s_tvalid <= 1'b0;
    while (sb.replies_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_area(logic [15:0] first, logic [15:0] last);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_AREA_FIRST;
    cfg_wdata <= first;
    @(posedge clk);
    cfg_index <= REG_AREA_END;
    cfg_wdata <= last;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_area(first, last);
  endtask

  // Extents mostly land in and around the data area with lengths small
  // enough that many fit, so allocations have to step over several clashes.
  task automatic random_items(int count);
    alloc_cmd_t  c;
    int unsigned span;
    int unsigned pick;
    span = (sb.area_end > sb.area_first) ? sb.area_end - sb.area_first : 2000;
    for (int i = 0; i < count; i++) begin
      if (i == count / 3) wait_all_replies();
      c.slot   = 6'($urandom);
      c.used   = ($urandom_range(0, 9) < 7);
      c.start  = 16'($urandom);
      c.length = 16'($urandom);
      c.req    = 16'($urandom);
      c.cmd    = ($urandom_range(0, 9) < 3) ? CMD_ALLOC : CMD_WRITE;
      pick     = $urandom_range(0, 99);
      if (c.cmd == CMD_WRITE) begin
        if (pick < 90) begin
          c.start = 16'(sb.area_first + $urandom_range(0, span + 40) - 20);
        end
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          c.length = 16'd0;
        end else if (pick < 96) begin
          c.length = 16'($urandom_range(1, span / 16 + 1));
        end
      end else begin
        if (pick < 70) begin
          c.req = 16'($urandom_range(1, span / 8 + 1));
        end else if (pick < 90) begin
          c.req = 16'($urandom_range(1, span));
        end else begin
          c.req = 16'($urandom_range(1, 65535));
        end
      end
      send_word(c);
    end
  endtask

  initial begin : result_sink
    int          gap;
    int unsigned words_taken;
    bit          calm;
    words_taken = 0;
    calm        = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      gap = pick_gap(calm);
      // Long hold-off so the block backs up while words keep coming.
      if (words_taken % 500 == 300) gap = 400;
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      sb.check_reply(alloc_reply_t'(m_tdata));
      words_taken++;
    end
  end

  initial begin : stimulus
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset area is [299, 2880).
    send_word(alloc_cmd(16'd1));
    send_word(alloc_cmd(16'd65535));
    send_word(alloc_cmd(16'd0));
    send_word(alloc_cmd(16'd2581));
    send_word(alloc_cmd(16'd2582));
    send_word(write_cmd(6'd0, 1'b1, 16'd299, 16'd100));
    send_word(alloc_cmd(16'd50));
    // A used zero-length extent inside the window drags the candidate to it.
    send_word(write_cmd(6'd63, 1'b1, 16'd500, 16'd0));
    send_word(alloc_cmd(16'd200));
    send_word(write_cmd(6'd5, 1'b0, 16'd65535, 16'd65535));
    send_word(write_cmd(6'd6, 1'b1, 16'd65535, 16'd65535));
    send_word(alloc_cmd(16'd10));
    // Overwrite a live entry with one that covers the whole area.
    send_word(write_cmd(6'd6, 1'b1, 16'd0, 16'd65535));
    send_word(alloc_cmd(16'd1));
    send_word(write_cmd(6'd6, 1'b0, 16'd0, 16'd0));
    send_word(write_cmd(6'd0, 1'b0, 16'd0, 16'd0));
    send_word(write_cmd(6'd63, 1'b0, 16'd0, 16'd0));
    send_word(write_cmd(6'd42, 1'b1, 16'd2800, 16'd80));
    send_word(alloc_cmd(16'd2501));
    send_word(alloc_cmd(16'd2502));
    send_word(write_cmd(6'd42, 1'b0, 16'd0, 16'd0));

    random_items(166);
    foreach (phase_first[p]) begin
      wait_all_replies();
      set_area(phase_first[p], phase_last[p]);
      random_items(166);
    end

    wait_all_replies();
    repeat (64) @(posedge clk);
    if (sb.failures == 0 && sb.replies_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
